// ===== sv/aes_pkg.sv =====
// Package with AES constants, state machine type and S-box function.
`default_nettype none
package aes_pkg;
    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_INIT, ST_ROUND, ST_DONE
    } t_state;

    localparam logic [2:0] CFG_KEY_MODE = 3'd0;
    localparam logic [2:0] CFG_KEY_A    = 3'd1;
    localparam logic [2:0] CFG_KEY_B    = 3'd2;
    localparam logic [2:0] CFG_KEY_C    = 3'd3;
    localparam logic [2:0] CFG_KEY_D    = 3'd4;
    localparam logic [1:0] MODE_128     = 2'b00;
    localparam logic [1:0] MODE_192     = 2'b01;
    localparam logic [1:0] MODE_256     = 2'b10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction
endpackage
`default_nettype wire

// ===== sv/aes_round_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module aes_round_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/aes_block_encrypt_top.sv =====
// AES-128/192/256 encryption with one shared round unit and round-key RAM.
// During the rounds one key word is read per cycle, and each round is applied as the
// last word of its round key arrives. The first block after reset or a configuration
// write first runs key expansion, which builds the key words in order from the key
// and the word Nk places back, and writes them to the round-key RAM.
// Synchronous active-low reset clears control state and configuration; the key store
// is rebuilt on use.
`default_nettype none
module aes_block_encrypt_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_block_low,
    input  wire logic [63:0] i_block_high,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [63:0] o_cipher_low,
    output logic      [63:0] o_cipher_high
);
    import aes_pkg::*;

    t_state r_state, n_state;
    logic [1:0]   r_mode;
    logic [255:0] r_key;
    logic         r_stale;
    logic [5:0]   r_idx;      // key word index
    logic [31:0]  r_prev;     // last expanded word
    logic [7:0]   r_rcon;
    logic [2:0]   r_nk_cnt;   // i mod Nk
    logic [127:0] r_st;
    logic [127:0] r_rk;       // round key being assembled
    logic [1:0]   r_col;
    logic [3:0]   r_round;
    logic         r_rd_ok;    // read data valid this cycle
    logic [31:0]  ram_rdata;
    logic [31:0]  w_new;
    logic         ram_we;
    logic [5:0]   ram_raddr;
    logic [3:0]   nk, nr;
    logic [5:0]   total;
    logic [127:0] sb, mc, rnd;
    logic [31:0]  t;

    assign nk    = (r_mode == MODE_128) ? 4'd4 : (r_mode == MODE_192) ? 4'd6 : 4'd8;
    assign nr    = nk + 4'd6;
    assign total = {nk + 4'd7, 2'b00};

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_valid     = (r_state == ST_DONE);

    // Key schedule word: direct key word, or recurrence on previous word.
    always_comb begin
        t = r_prev;
        if (r_nk_cnt == 3'd0) begin
            t = sub_word({r_prev[23:0], r_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_nk_cnt == 3'd4) begin
            t = sub_word(r_prev);
        end
        if (r_idx < {2'b00, nk}) begin
            w_new = {r_key[32*r_idx[2:0] +: 8], r_key[32*r_idx[2:0]+8 +: 8],
                     r_key[32*r_idx[2:0]+16 +: 8], r_key[32*r_idx[2:0]+24 +: 8]};
        end else begin
            w_new = t ^ ram_rdata;
        end
    end

    // Store writes during expansion; reads word i-Nk or the round key.
    // At the last column of a round the first word of the next round is fetched.
    assign ram_we    = (r_state == ST_EXPAND) && r_rd_ok;
    assign ram_raddr = (r_state == ST_EXPAND) ? r_idx - {2'b00, nk}
                     : (r_state == ST_ROUND && r_col == 2'd0) ? {r_round + 4'd1, 2'b00}
                                                              : {r_round, r_col};

    aes_round_ram #(.WIDTH(32), .DEPTH(64)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared round: SubBytes, ShiftRows, MixColumns (not in the final round).
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[8*(4*c+r) +: 8] = SBOX[r_st[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sb[8*(4*c)   +: 8];
            a1 = sb[8*(4*c+1) +: 8];
            a2 = sb[8*(4*c+2) +: 8];
            a3 = sb[8*(4*c+3) +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mc[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        rnd = (r_round == 4'd0) ? r_st : ((r_round == nr) ? sb : mc);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = r_stale ? ST_EXPAND : ST_INIT;
                end
            end
            ST_EXPAND: begin
                if (r_rd_ok && r_idx == total - 6'd1) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_col == 2'd0 && r_round == nr) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_128;
            r_key   <= '0;
            r_stale <= 1'b1;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEY_MODE: begin
                        r_mode  <= (i_cfg_data[1:0] == 2'b11) ? MODE_256 : i_cfg_data[1:0];
                        r_stale <= 1'b1;
                    end
                    CFG_KEY_A: begin r_key[63:0]    <= i_cfg_data; r_stale <= 1'b1; end
                    CFG_KEY_B: begin r_key[127:64]  <= i_cfg_data; r_stale <= 1'b1; end
                    CFG_KEY_C: begin r_key[191:128] <= i_cfg_data; r_stale <= 1'b1; end
                    CFG_KEY_D: begin r_key[255:192] <= i_cfg_data; r_stale <= 1'b1; end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_EXPAND: begin
                    r_rd_ok <= ~r_rd_ok;
                    if (r_rd_ok && r_idx == total - 6'd1) begin
                        r_stale <= 1'b0;
                    end
                end
                ST_ROUND: r_rd_ok <= 1'b1;
                default:  r_rd_ok <= 1'b0;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_st     <= {i_block_high, i_block_low};
                r_idx    <= '0;
                r_nk_cnt <= '0;
                r_rcon   <= 8'h01;
                r_round  <= '0;
                r_col    <= '0;
            end
            ST_EXPAND: begin
                if (r_rd_ok) begin
                    r_prev <= w_new;
                    r_idx  <= r_idx + 6'd1;
                    if (r_nk_cnt == 3'(nk - 4'd1)) begin
                        r_nk_cnt <= '0;
                    end else begin
                        r_nk_cnt <= r_nk_cnt + 3'd1;
                    end
                    if (r_nk_cnt == 3'd0 && r_idx >= {2'b00, nk}) begin
                        r_rcon <= xtime(r_rcon);
                    end
                end
            end
            ST_INIT: begin
                r_round <= '0;
                r_col   <= 2'd1;
            end
            ST_ROUND: begin
                // One key word arrives per cycle; column r_col-1 is in ram_rdata.
                for (int r = 0; r < 4; r++) begin
                    r_rk[8*(4*(2'(r_col - 2'd1))+r) +: 8] <= ram_rdata[31-8*r -: 8];
                end
                r_col <= r_col + 2'd1;
                if (r_col == 2'd0) begin
                    r_st    <= rnd ^ {ram_rdata[7:0], ram_rdata[15:8], ram_rdata[23:16],
                                      ram_rdata[31:24], r_rk[95:0]};
                    r_round <= r_round + 4'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_cipher_low  = r_st[63:0];
    assign o_cipher_high = r_st[127:64];
endmodule
`default_nettype wire
